>>> rtl/core/lsf_pkg.sv
// Shared types, widths and helpers for the least-squares line fit block.
// Used by lsf_alu and least_squares_line_fit_top; depends on nothing.
package lsf_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int IN_FRAC_BITS   = 4;
  localparam int COEF_W         = 48;
  localparam int PRED_W         = 47;
  localparam int CNT_W          = $clog2(MAX_SAMPLES + 1);
  localparam int SX_W           = SAMPLE_BITS + CNT_W - 1;
  localparam int SXX_W          = 2 * SAMPLE_BITS + CNT_W - 2;
  localparam int SXY_W          = 2 * SAMPLE_BITS + CNT_W - 1;
  // Operand widths of the shared multiply / divide unit.
  localparam int OPA_W          = 76;
  localparam int OPB_W          = 64;
  localparam int DCNT_W         = $clog2(OPA_W);

  localparam logic [OPA_W-1:0] COEF_NEG_LIM = OPA_W'(1) << (COEF_W - 1);
  localparam logic [OPA_W-1:0] COEF_MAX     = COEF_NEG_LIM - OPA_W'(1);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PREDICT = 1'b1;
  localparam logic KIND_FIT   = 1'b0;
  localparam logic KIND_PRED  = 1'b1;

  // Command to the shared arithmetic unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_cmd_t;

  // Clamp a magnitude to the coefficient range and apply the sign.
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic neg,
                                                        input logic [OPA_W-1:0] m);
    logic [OPA_W-1:0]  lim;
    logic [COEF_W-1:0] v;
    lim = neg ? COEF_NEG_LIM : COEF_MAX;
    v   = (m > lim) ? lim[COEF_W-1:0] : m[COEF_W-1:0];
    return neg ? -$signed(v) : $signed(v);
  endfunction

endpackage

>>> rtl/core/lsf_alu.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide.
// Depends on lsf_pkg for widths and the command struct.
module lsf_alu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lsf_pkg::alu_cmd_t          cmd,
  input  logic [lsf_pkg::OPA_W-1:0]  opa,
  input  logic [lsf_pkg::OPB_W-1:0]  opb,
  output logic                       done,
  output logic [lsf_pkg::OPA_W-1:0]  res
);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic                        div_r, div_nxt;
  logic [lsf_pkg::OPA_W-1:0]   a_r, a_nxt;
  logic [lsf_pkg::OPA_W-1:0]   acc_r, acc_nxt;
  logic [lsf_pkg::OPB_W-1:0]   b_r, b_nxt;
  logic [lsf_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [lsf_pkg::OPB_W:0]     trial;
  logic [lsf_pkg::OPB_W+1:0]   diff;

  // Divide trial: shift the next dividend bit into the remainder and subtract.
  assign trial = {acc_r[lsf_pkg::OPB_W-1:0], a_r[lsf_pkg::OPA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, b_r};

  // One multiply bit or one quotient bit per cycle.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    if (cmd.start) begin
      run_nxt = 1'b1;
      div_nxt = cmd.is_div;
      a_nxt   = opa;
      b_nxt   = opb;
      acc_nxt = '0;
      cnt_nxt = lsf_pkg::DCNT_W'(lsf_pkg::OPA_W - 1);
    end else if (run_r) begin
      if (div_r) begin
        if (!diff[lsf_pkg::OPB_W+1]) begin
          acc_nxt = lsf_pkg::OPA_W'(diff[lsf_pkg::OPB_W:0]);
        end else begin
          acc_nxt = lsf_pkg::OPA_W'(trial);
        end
        a_nxt   = {a_r[lsf_pkg::OPA_W-2:0], ~diff[lsf_pkg::OPB_W+1]};
        cnt_nxt = cnt_r - lsf_pkg::DCNT_W'(1);
        if (cnt_r == '0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
        if (b_r[lsf_pkg::OPB_W-1:1] == '0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // Control state is reset; the datapath is loaded on each start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign res  = div_r ? a_r : acc_r;

endmodule

>>> rtl/core/least_squares_line_fit_top.sv
// Least-squares line fit: sample accumulation, fit and prediction.
// Depends on lsf_pkg and instantiates the shared unit lsf_alu.
//
// Usage: the input channel carries one beat per item. A load beat (op 0)
// adds an (x, y) pair to the running sums; once 1024 samples are held,
// further pairs are dropped. A load beat with last set then runs the fit
// and returns one fit beat (kind 0) with slope, intercept and fit_error.
// A predict beat (op 1) returns one beat (kind 1) with slope*x+intercept,
// clamped at zero with no_demand set when negative.
// Every product and quotient goes through one shift-add /
// restoring-divide unit, one bit per cycle. A fit runs two divisions
// plus five serial products. in_ready is high only while the block is
// idle, so one item is worked on at a time.
// The result beat is held in place until out_ready; the block takes no
// new beat until it is taken. Reset clears the sums, the sample count
// and both coefficients to zero.
module least_squares_line_fit_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [lsf_pkg::SAMPLE_BITS-1:0] in_x_value,
  input  logic signed [lsf_pkg::SAMPLE_BITS-1:0] in_y_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_kind,
  output logic signed [lsf_pkg::COEF_W-1:0]   out_slope,
  output logic signed [lsf_pkg::COEF_W-1:0]   out_intercept,
  output logic [lsf_pkg::PRED_W-1:0]          out_predicted,
  output logic                                out_no_demand,
  output logic                                out_fit_error
);

  localparam int VW = lsf_pkg::OPA_W + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  typedef enum logic [9:0] {
    ST_LXX  = 10'b0000000001,
    ST_LXY  = 10'b0000000010,
    ST_NXY  = 10'b0000000100,
    ST_SXSY = 10'b0000001000,
    ST_NXX  = 10'b0000010000,
    ST_SXSX = 10'b0000100000,
    ST_SDIV = 10'b0001000000,
    ST_BMUL = 10'b0010000000,
    ST_IDIV = 10'b0100000000,
    ST_PMUL = 10'b1000000000
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic signed [lsf_pkg::SX_W-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic [lsf_pkg::SXX_W-1:0]         sxx_r, sxx_nxt;
  logic signed [lsf_pkg::SXY_W-1:0]  sxy_r, sxy_nxt;
  logic [lsf_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [lsf_pkg::COEF_W-1:0] slope_r, slope_nxt, icpt_r, icpt_nxt;
  logic signed [lsf_pkg::SAMPLE_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                              last_r, last_nxt;
  logic signed [63:0]                t_r, t_nxt, num_r, num_nxt, den_r, den_nxt;
  logic signed [VW-1:0]              v_r, v_nxt;
  logic                              mneg_r, mneg_nxt;
  logic                              kind_r, kind_nxt, nd_r, nd_nxt, err_r, err_nxt;
  logic [lsf_pkg::PRED_W-1:0]        pred_r, pred_nxt;

  lsf_pkg::alu_cmd_t           cmd;
  logic [lsf_pkg::OPA_W-1:0]   opa, res;
  logic [lsf_pkg::OPB_W-1:0]   opb;
  logic                        alu_done;
  logic                        op_neg;

  logic [lsf_pkg::SX_W:0]          ax_sum, ay_sum;
  logic [lsf_pkg::SXY_W:0]         axy;
  logic [lsf_pkg::SAMPLE_BITS:0]   ax_in, ay_in;
  logic [lsf_pkg::COEF_W:0]        aslope;
  logic [64:0]                     anum;
  logic [VW-1:0]                   av;
  logic signed [lsf_pkg::OPA_W:0]  mres;
  logic signed [63:0]              den_w;
  logic signed [VW-1:0]            p_w;
  logic [VW-5:0]                   pr_w;

  // Magnitudes of the signed operands.
  assign ax_sum = sx_r[lsf_pkg::SX_W-1] ? -(lsf_pkg::SX_W+1)'(sx_r) : (lsf_pkg::SX_W+1)'(sx_r);
  assign ay_sum = sy_r[lsf_pkg::SX_W-1] ? -(lsf_pkg::SX_W+1)'(sy_r) : (lsf_pkg::SX_W+1)'(sy_r);
  assign axy    = sxy_r[lsf_pkg::SXY_W-1] ? -(lsf_pkg::SXY_W+1)'(sxy_r)
                                          : (lsf_pkg::SXY_W+1)'(sxy_r);
  assign ax_in  = x_r[lsf_pkg::SAMPLE_BITS-1] ? -(lsf_pkg::SAMPLE_BITS+1)'(x_r)
                                              : (lsf_pkg::SAMPLE_BITS+1)'(x_r);
  assign ay_in  = y_r[lsf_pkg::SAMPLE_BITS-1] ? -(lsf_pkg::SAMPLE_BITS+1)'(y_r)
                                              : (lsf_pkg::SAMPLE_BITS+1)'(y_r);
  assign aslope = slope_r[lsf_pkg::COEF_W-1] ? -(lsf_pkg::COEF_W+1)'(slope_r)
                                             : (lsf_pkg::COEF_W+1)'(slope_r);
  assign anum   = num_r[63] ? -65'(num_r) : 65'(num_r);
  assign av     = v_r[VW-1] ? -v_r : v_r;

  // Signed product from the unsigned result of the shared unit.
  assign mres = mneg_r ? -$signed({1'b0, res}) : $signed({1'b0, res});

  // Operands for the current step.
  always_comb begin
    opa    = '0;
    opb    = '0;
    op_neg = 1'b0;
    cmd    = '{start: (state_r == S_ISSUE), is_div: 1'b0};
    case (step_r)
      ST_LXX: begin
        opa = lsf_pkg::OPA_W'(ax_in);
        opb = lsf_pkg::OPB_W'(ax_in);
      end
      ST_LXY: begin
        opa    = lsf_pkg::OPA_W'(ax_in);
        opb    = lsf_pkg::OPB_W'(ay_in);
        op_neg = x_r[lsf_pkg::SAMPLE_BITS-1] ^ y_r[lsf_pkg::SAMPLE_BITS-1];
      end
      ST_NXY: begin
        opa    = lsf_pkg::OPA_W'(axy);
        opb    = lsf_pkg::OPB_W'(cnt_r);
        op_neg = sxy_r[lsf_pkg::SXY_W-1];
      end
      ST_SXSY: begin
        opa    = lsf_pkg::OPA_W'(ax_sum);
        opb    = lsf_pkg::OPB_W'(ay_sum);
        op_neg = sx_r[lsf_pkg::SX_W-1] ^ sy_r[lsf_pkg::SX_W-1];
      end
      ST_NXX: begin
        opa = lsf_pkg::OPA_W'(sxx_r);
        opb = lsf_pkg::OPB_W'(cnt_r);
      end
      ST_SXSX: begin
        opa = lsf_pkg::OPA_W'(ax_sum);
        opb = lsf_pkg::OPB_W'(ax_sum);
      end
      ST_SDIV: begin
        opa        = lsf_pkg::OPA_W'(anum) << lsf_pkg::COEF_FRAC_BITS;
        opb        = lsf_pkg::OPB_W'(den_r);
        cmd.is_div = 1'b1;
      end
      ST_BMUL: begin
        opa    = lsf_pkg::OPA_W'(aslope);
        opb    = lsf_pkg::OPB_W'(ax_sum);
        op_neg = slope_r[lsf_pkg::COEF_W-1] ^ sx_r[lsf_pkg::SX_W-1];
      end
      ST_IDIV: begin
        opa        = lsf_pkg::OPA_W'(av);
        opb        = lsf_pkg::OPB_W'(cnt_r) << lsf_pkg::IN_FRAC_BITS;
        cmd.is_div = 1'b1;
      end
      ST_PMUL: begin
        opa    = lsf_pkg::OPA_W'(aslope);
        opb    = lsf_pkg::OPB_W'(ax_in);
        op_neg = slope_r[lsf_pkg::COEF_W-1] ^ x_r[lsf_pkg::SAMPLE_BITS-1];
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  lsf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .opa   (opa),
    .opb   (opb),
    .done  (alu_done),
    .res   (res)
  );

  assign den_w = t_r - 64'(mres);
  assign p_w   = VW'(mres) + (VW'(icpt_r) <<< lsf_pkg::IN_FRAC_BITS);
  assign pr_w  = p_w[VW-1:4];

  // Sequencer: accept a beat, walk the steps, hold the result beat.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sxx_nxt   = sxx_r;
    sxy_nxt   = sxy_r;
    cnt_nxt   = cnt_r;
    slope_nxt = slope_r;
    icpt_nxt  = icpt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    last_nxt  = last_r;
    t_nxt     = t_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    v_nxt     = v_r;
    mneg_nxt  = mneg_r;
    kind_nxt  = kind_r;
    nd_nxt    = nd_r;
    err_nxt   = err_r;
    pred_nxt  = pred_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt    = in_x_value;
          y_nxt    = in_y_value;
          last_nxt = in_last;
          if (in_op == lsf_pkg::OP_PREDICT) begin
            step_nxt  = ST_PMUL;
            state_nxt = S_ISSUE;
          end else if (cnt_r < lsf_pkg::CNT_W'(lsf_pkg::MAX_SAMPLES)) begin
            sx_nxt    = sx_r + lsf_pkg::SX_W'(in_x_value);
            sy_nxt    = sy_r + lsf_pkg::SX_W'(in_y_value);
            cnt_nxt   = cnt_r + lsf_pkg::CNT_W'(1);
            step_nxt  = ST_LXX;
            state_nxt = S_ISSUE;
          end else if (in_last) begin
            step_nxt  = ST_NXY;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        mneg_nxt  = op_neg;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (alu_done) begin
          state_nxt = S_ISSUE;
          case (step_r)
            ST_LXX: begin
              sxx_nxt  = sxx_r + lsf_pkg::SXX_W'(res);
              step_nxt = ST_LXY;
            end
            ST_LXY: begin
              sxy_nxt = sxy_r + lsf_pkg::SXY_W'(mres);
              if (last_r) begin
                step_nxt = ST_NXY;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            ST_NXY: begin
              t_nxt    = 64'(mres);
              step_nxt = ST_SXSY;
            end
            ST_SXSY: begin
              num_nxt  = t_r - 64'(mres);
              step_nxt = ST_NXX;
            end
            ST_NXX: begin
              t_nxt    = 64'(mres);
              step_nxt = ST_SXSX;
            end
            ST_SXSX: begin
              den_nxt  = den_w;
              step_nxt = ST_SDIV;
              // A flat or too-small set gives no fit.
              if (den_w <= 64'sd0) begin
                slope_nxt = '0;
                icpt_nxt  = '0;
                err_nxt   = 1'b1;
                kind_nxt  = lsf_pkg::KIND_FIT;
                nd_nxt    = 1'b0;
                pred_nxt  = '0;
                sx_nxt    = '0;
                sy_nxt    = '0;
                sxx_nxt   = '0;
                sxy_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = S_OUT;
              end
            end
            ST_SDIV: begin
              slope_nxt = lsf_pkg::sat_coef(num_r[63], res);
              step_nxt  = ST_BMUL;
            end
            ST_BMUL: begin
              v_nxt    = (VW'(sy_r) <<< lsf_pkg::COEF_FRAC_BITS) - VW'(mres);
              step_nxt = ST_IDIV;
            end
            ST_IDIV: begin
              icpt_nxt  = lsf_pkg::sat_coef(v_r[VW-1], res);
              err_nxt   = 1'b0;
              kind_nxt  = lsf_pkg::KIND_FIT;
              nd_nxt    = 1'b0;
              pred_nxt  = '0;
              sx_nxt    = '0;
              sy_nxt    = '0;
              sxx_nxt   = '0;
              sxy_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_OUT;
            end
            ST_PMUL: begin
              kind_nxt = lsf_pkg::KIND_PRED;
              err_nxt  = 1'b0;
              nd_nxt   = p_w[VW-1];
              if (p_w[VW-1]) begin
                pred_nxt = '0;
              end else if (|pr_w[VW-5:lsf_pkg::PRED_W]) begin
                pred_nxt = '1;
              end else begin
                pred_nxt = pr_w[lsf_pkg::PRED_W-1:0];
              end
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, running sums and held coefficients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_LXX;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      cnt_r   <= '0;
      slope_r <= '0;
      icpt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sxx_r   <= sxx_nxt;
      sxy_r   <= sxy_nxt;
      cnt_r   <= cnt_nxt;
      slope_r <= slope_nxt;
      icpt_r  <= icpt_nxt;
    end
  end

  // Working values and the result beat.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    last_r <= last_nxt;
    t_r    <= t_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    v_r    <= v_nxt;
    mneg_r <= mneg_nxt;
    kind_r <= kind_nxt;
    nd_r   <= nd_nxt;
    err_r  <= err_nxt;
    pred_r <= pred_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign out_kind      = kind_r;
  assign out_slope     = slope_r;
  assign out_intercept = icpt_r;
  assign out_predicted = pred_r;
  assign out_no_demand = nd_r;
  assign out_fit_error = err_r;

endmodule
